/* rtl/rcls_pkg.sv */
// shared constants and codes for the reversible circular list store
`default_nettype none

package rcls_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 2;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

/* rtl/reversible_circular_list_store.sv */
// Ordered store of signed 32-bit values held in a ring memory
//
// Requests come in on cmd/value with in_valid/in_ready; results leave on
// item_value/status/last with out_valid/out_ready. Commands: append, delete
// tail, display all (head to tail), reverse order.
// Append and reverse answer in the cycle after the request.
// Delete reads the ring memory into the read data register, and its result
// is registered from that read data in the S_DEL state.
// Display issues one memory read per cycle while the receiver is not stalling
// and gives one result per stored entry, last marking the tail.
// Delete or display on an empty store answers in the cycle after the request
// with one result of status empty; append to a full store gives one result
// with status full.
// A new request is taken once the previous one has finished and the output
// register is empty or being drained, so one request is in work at a time.
// A stalled receiver holds the result register and freezes a display walk.
// Reset empties the store and clears the direction flag; memory contents
// are not cleared and are only read where they were written.
`default_nettype none

module reversible_circular_list_store
  import rcls_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic        [CMD_W-1:0]    cmd,
  input  wire logic signed [DATA_W-1:0]   value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed      [DATA_W-1:0]   item_value,
  output logic             [STATUS_W-1:0] status,
  output logic                            last
);

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_SHOW
  } state_t;

  state_t state;

  logic [PTR_W-1:0] front;
  logic [PTR_W-1:0] back;
  logic [CNT_W-1:0] count;
  logic             reversed;
  logic [PTR_W-1:0] walk;
  logic [CNT_W-1:0] remain;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic              wr_en;
  logic [PTR_W-1:0]  wr_addr;

  logic accept;
  logic out_free;
  logic is_full;
  logic is_empty;
  logic [PTR_W-1:0] front_next;
  logic [PTR_W-1:0] front_prev;
  logic [PTR_W-1:0] back_prev;
  logic [PTR_W-1:0] walk_step;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) && out_free;
  assign accept     = in_valid && in_ready;
  assign is_full    = (count == CNT_FULL);
  assign is_empty   = (count == '0);
  assign front_next = ring_next(front);
  assign front_prev = ring_prev(front);
  assign back_prev  = ring_prev(back);
  assign walk_step  = reversed ? ring_prev(walk) : ring_next(walk);

  // memory access selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = walk_step;
    wr_en   = 1'b0;
    wr_addr = back;
    if (accept) begin
      case (cmd)
        CMD_APPEND: begin
          wr_en   = !is_full;
          wr_addr = reversed ? front_prev : back;
        end
        CMD_DELETE: begin
          rd_en   = !is_empty;
          rd_addr = reversed ? front : back_prev;
        end
        CMD_DISPLAY: begin
          rd_en   = !is_empty;
          rd_addr = reversed ? back_prev : front;
        end
        default: begin
          rd_en = 1'b0;
        end
      endcase
    end else if (state == S_SHOW && out_free && remain != CNT_W'(1)) begin
      // prefetch the next entry while the current one goes out
      rd_en   = 1'b1;
      rd_addr = walk_step;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      front     <= '0;
      back      <= '0;
      count     <= '0;
      reversed  <= 1'b0;
      walk      <= '0;
      remain    <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_value <= '0;
            status     <= ST_OK;
            last       <= 1'b1;
            case (cmd)
              CMD_APPEND: begin
                out_valid <= 1'b1;
                if (is_full) begin
                  status <= ST_FULL;
                end else begin
                  count <= count + 1'b1;
                  if (reversed) begin
                    front <= front_prev;
                  end else begin
                    back <= ring_next(back);
                  end
                end
              end
              CMD_DELETE: begin
                if (is_empty) begin
                  out_valid <= 1'b1;
                  status    <= ST_EMPTY;
                end else begin
                  count <= count - 1'b1;
                  state <= S_DEL;
                  if (reversed) begin
                    front <= front_next;
                  end else begin
                    back <= back_prev;
                  end
                end
              end
              CMD_DISPLAY: begin
                if (is_empty) begin
                  out_valid <= 1'b1;
                  status    <= ST_EMPTY;
                end else begin
                  walk   <= reversed ? back_prev : front;
                  remain <= count;
                  state  <= S_SHOW;
                end
              end
              CMD_REVERSE: begin
                out_valid <= 1'b1;
                reversed  <= !reversed;
              end
              default: begin
                out_valid <= 1'b0;
              end
            endcase
          end
        end
        S_DEL: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            item_value <= rd_data;
            status     <= ST_OK;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_SHOW: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            item_value <= rd_data;
            status     <= ST_OK;
            last       <= (remain == CNT_W'(1));
            remain     <= remain - 1'b1;
            walk       <= walk_step;
            if (remain == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ring bookkeeping: back always sits count entries past front
  logic [CNT_W:0] ptr_sum;
  logic [PTR_W-1:0] back_expect;
  assign ptr_sum     = (CNT_W + 1)'(front) + (CNT_W + 1)'(count);
  assign back_expect = (ptr_sum >= (CNT_W + 1)'(CAPACITY)) ?
                       PTR_W'(ptr_sum - (CNT_W + 1)'(CAPACITY)) : PTR_W'(ptr_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count above capacity");

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    back_expect == back)
    else $error("front, back and count disagree");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_APPEND && !is_full |=> count == $past(count) + 1'b1)
    else $error("append did not add an entry");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SHOW |-> remain != '0 && remain <= count)
    else $error("display walk out of range");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY || status == ST_FULL) |-> last && item_value == '0)
    else $error("error result not single");

endmodule

`default_nettype wire
